// ===== rtl/core/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants for point_screen_projection
// Field widths, item kinds, register indexes and a saturation helper.
// ----------------------------------------------------------------------------
package psp_pkg;

   // matrix and arithmetic sizes
   localparam int MATRIX_ENTRIES = 16;
   localparam int MAT_IDX_W      = $clog2(MATRIX_ENTRIES);
   localparam int DIM            = 4;
   localparam int Q_W            = 32;
   localparam int TERM_W         = 48;
   localparam int ACC_W          = 50;
   localparam int NUM_W          = 48;
   localparam int DEN_W          = 33;
   localparam int QUO_BITS       = 16;
   localparam int REM_W          = DEN_W + QUO_BITS;
   localparam int DIV_STAGES     = QUO_BITS + 1;
   localparam int SIZE_W         = 14;
   localparam int PIX_W          = 16;

   // input modes
   localparam logic [1:0] MODE_VIEW_WR  = 2'd0;
   localparam logic [1:0] MODE_PROJ_WR  = 2'd1;
   localparam logic [1:0] MODE_POINT    = 2'd2;

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = SIZE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEWPORT_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEWPORT_HEIGHT = 1'b1;
   localparam logic [SIZE_W-1:0] VIEWPORT_WIDTH_RST  = 14'd1920;
   localparam logic [SIZE_W-1:0] VIEWPORT_HEIGHT_RST = 14'd1080;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_VIEW_WR,
      KIND_PROJ_WR,
      KIND_POINT
   } item_kind_type;

   typedef struct packed {
      item_kind_type         kind;
      logic [MAT_IDX_W-1:0]  coef_index;
      logic signed [Q_W-1:0] coef_value;
      logic signed [Q_W-1:0] point_x;
      logic signed [Q_W-1:0] point_y;
      logic signed [Q_W-1:0] point_z;
   } item_type;

   // saturate an accumulated sum to signed q16.16
   function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [Q_W-1:0] res;
      if (v[ACC_W-1:Q_W-1] != {(ACC_W-Q_W+1){v[ACC_W-1]}}) begin
         res = v[ACC_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         res = v[Q_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/psp_if.sv =====
// ----------------------------------------------------------------------------
// psp_if: request and response channels of point_screen_projection
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface psp_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          mode;
   logic [psp_pkg::MAT_IDX_W-1:0]       coef_index;
   logic signed [psp_pkg::Q_W-1:0]      coef_value;
   logic signed [psp_pkg::Q_W-1:0]      point_x;
   logic signed [psp_pkg::Q_W-1:0]      point_y;
   logic signed [psp_pkg::Q_W-1:0]      point_z;

   modport source (output valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                   input ready);
   modport sink   (input valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                   output ready);
endinterface

interface psp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [psp_pkg::PIX_W-1:0]    screen_x;
   logic signed [psp_pkg::PIX_W-1:0]    screen_y;
   logic                                degenerate;

   modport source (output valid, screen_x, screen_y, degenerate, input ready);
   modport sink   (input valid, screen_x, screen_y, degenerate, output ready);
endinterface

// ===== rtl/core/psp_front.sv =====
// ----------------------------------------------------------------------------
// psp_front: request intake
// Accepts items, classifies them by mode and queues them for the back end.
// ----------------------------------------------------------------------------
module psp_front (
   input  logic               clock,
   input  logic               reset,
   psp_req_if.sink            req_bus,
   input  logic               pop,
   output logic               head_valid,
   output psp_pkg::item_type  head_item
);

   logic [psp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [psp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [psp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   psp_pkg::item_type          entry_ff [psp_pkg::QUEUE_DEPTH];
   psp_pkg::item_type          new_item;
   logic                       accept;
   logic                       push;
   logic                       known;

   // classify by mode, unused mode is dropped
   always_comb begin
      new_item.coef_index = req_bus.coef_index;
      new_item.coef_value = req_bus.coef_value;
      new_item.point_x    = req_bus.point_x;
      new_item.point_y    = req_bus.point_y;
      new_item.point_z    = req_bus.point_z;
      known               = 1'b1;
      case (req_bus.mode)
         psp_pkg::MODE_VIEW_WR: new_item.kind = psp_pkg::KIND_VIEW_WR;
         psp_pkg::MODE_PROJ_WR: new_item.kind = psp_pkg::KIND_PROJ_WR;
         psp_pkg::MODE_POINT:   new_item.kind = psp_pkg::KIND_POINT;
         default: begin
            new_item.kind = psp_pkg::KIND_POINT;
            known         = 1'b0;
         end
      endcase
   end

   assign req_bus.ready = (count_ff != psp_pkg::QCNT_W'(psp_pkg::QUEUE_DEPTH));
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept && known;
   assign head_valid    = (count_ff != '0);
   assign head_item     = entry_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/core/psp_divide.sv =====
// ----------------------------------------------------------------------------
// psp_divide: pipelined restoring divider
// Range check, then one quotient bit per stage; saturated signed 16-bit pixel.
// ----------------------------------------------------------------------------
module psp_divide (
   input  logic                            clock,
   input  logic                            adv,
   input  logic [psp_pkg::NUM_W-1:0]       in_num,
   input  logic [psp_pkg::DEN_W-1:0]       in_den,
   input  logic                            in_neg,
   output logic signed [psp_pkg::PIX_W-1:0] quo
);

   localparam int N = psp_pkg::DIV_STAGES;

   logic [psp_pkg::REM_W-1:0]    rem_ff [N];
   logic [psp_pkg::DEN_W-1:0]    den_ff [N];
   logic [psp_pkg::QUO_BITS-1:0] quo_ff [N];
   logic                         neg_ff [N];
   logic                         sat_ff [N];
   logic [psp_pkg::QUO_BITS-1:0] mag;

   // entry stage: quotient of 2^16 or more saturates
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= psp_pkg::REM_W'(in_num);
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         neg_ff[0] <= in_neg;
         sat_ff[0] <= psp_pkg::REM_W'(in_num) >= {in_den, {psp_pkg::QUO_BITS{1'b0}}};
      end
   end

   // one compare and subtract per stage
   for (genvar k = 1; k < N; k++) begin : g_step
      localparam int BIT = psp_pkg::QUO_BITS - k;
      logic [psp_pkg::REM_W-1:0]    trial;
      logic                         ge;
      logic [psp_pkg::REM_W-1:0]    rem_in;
      logic [psp_pkg::QUO_BITS-1:0] quo_in;

      always_comb begin
         trial       = psp_pkg::REM_W'(den_ff[k-1]) << BIT;
         ge          = rem_ff[k-1] >= trial;
         rem_in      = ge ? rem_ff[k-1] - trial : rem_ff[k-1];
         quo_in      = quo_ff[k-1];
         quo_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in;
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   // apply sign and clamp to the pixel range
   assign mag = quo_ff[N-1];
   always_comb begin
      if (sat_ff[N-1] || mag[psp_pkg::QUO_BITS-1]) begin
         quo = neg_ff[N-1] ? {1'b1, {(psp_pkg::PIX_W-1){1'b0}}}
                           : {1'b0, {(psp_pkg::PIX_W-1){1'b1}}};
      end else begin
         quo = neg_ff[N-1] ? -$signed(mag) : $signed(mag);
      end
   end

endmodule

// ===== rtl/core/psp_xform.sv =====
// ----------------------------------------------------------------------------
// psp_xform: transform back end
// Matrix stores, view and projection products, viewport mapping, output reg.
// ----------------------------------------------------------------------------
module psp_xform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [psp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [psp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               head_valid,
   input  psp_pkg::item_type                  head_item,
   output logic                               pop,
   psp_rsp_if.source                          rsp_bus
);

   localparam int D = psp_pkg::DIM;

   logic signed [psp_pkg::Q_W-1:0]    view_ff [psp_pkg::MATRIX_ENTRIES];
   logic signed [psp_pkg::Q_W-1:0]    proj_ff [psp_pkg::MATRIX_ENTRIES];
   logic [psp_pkg::SIZE_W-1:0]        size_ff [2];
   logic                              adv;

   logic signed [psp_pkg::Q_W-1:0]    s1_pt [3];
   logic signed [2*psp_pkg::Q_W-1:0]  s1_prod [D][3];
   logic signed [psp_pkg::TERM_W-1:0] s1_term_in [D][D];
   logic signed [psp_pkg::TERM_W-1:0] s1_term_ff [D][D];
   logic                              s1_vld_ff;
   psp_pkg::item_kind_type            s1_kind_ff;
   logic [psp_pkg::MAT_IDX_W-1:0]     s1_idx_ff;
   logic signed [psp_pkg::Q_W-1:0]    s1_val_ff;

   logic signed [psp_pkg::ACC_W-1:0]  s2_sum [D];
   logic signed [psp_pkg::Q_W-1:0]    s2_eye_ff [D];
   logic                              s2_vld_ff;
   psp_pkg::item_kind_type            s2_kind_ff;
   logic [psp_pkg::MAT_IDX_W-1:0]     s2_idx_ff;
   logic signed [psp_pkg::Q_W-1:0]    s2_val_ff;

   logic signed [2*psp_pkg::Q_W-1:0]  s3_prod [D][D];
   logic signed [psp_pkg::TERM_W-1:0] s3_term_ff [D][D];
   logic                              s3_vld_ff;

   logic signed [psp_pkg::ACC_W-1:0]  s4_sum [D];
   logic signed [psp_pkg::Q_W-1:0]    s4_clip_ff [D];
   logic                              s4_vld_ff;

   logic signed [psp_pkg::Q_W:0]      s5_sum [2];
   logic signed [psp_pkg::NUM_W-1:0]  s5_prod_ff [2];
   logic signed [psp_pkg::Q_W-1:0]    s5_w_ff;
   logic                              s5_vld_ff;
   logic                              s5_deg_ff;

   logic signed [psp_pkg::NUM_W-1:0]  s6_num_ff [2];
   logic signed [psp_pkg::DEN_W-1:0]  s6_den_ff;
   logic                              s6_vld_ff;
   logic                              s6_deg_ff;

   logic [psp_pkg::NUM_W-1:0]         s7_anum_ff [2];
   logic [psp_pkg::DEN_W-1:0]         s7_aden_ff;
   logic                              s7_neg_ff [2];
   logic                              s7_vld_ff;
   logic                              s7_deg_ff;

   logic                              dv_vld_ff [psp_pkg::DIV_STAGES];
   logic                              dv_deg_ff [psp_pkg::DIV_STAGES];
   logic signed [psp_pkg::PIX_W-1:0]  quo [2];

   logic                              rsp_valid_ff;
   logic signed [psp_pkg::PIX_W-1:0]  screen_x_ff;
   logic signed [psp_pkg::PIX_W-1:0]  screen_y_ff;
   logic                              degenerate_ff;

   // whole pipeline moves unless the output register is held
   assign adv = !rsp_valid_ff || rsp_bus.ready;
   assign pop = adv && head_valid;

   // viewport registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= psp_pkg::VIEWPORT_WIDTH_RST;
         size_ff[1] <= psp_pkg::VIEWPORT_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            psp_pkg::CSR_VIEWPORT_WIDTH:  size_ff[0] <= csr_wdata;
            psp_pkg::CSR_VIEWPORT_HEIGHT: size_ff[1] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // matrix stores: view written on dequeue, projection at stage 3 entry
   always_ff @(posedge clock) begin
      if (pop && head_item.kind == psp_pkg::KIND_VIEW_WR) begin
         view_ff[head_item.coef_index] <= head_item.coef_value;
      end
      if (adv && s2_vld_ff && s2_kind_ff == psp_pkg::KIND_PROJ_WR) begin
         proj_ff[s2_idx_ff] <= s2_val_ff;
      end
   end

   // stage 1: view matrix products, w column is times one
   always_comb begin
      s1_pt[0] = head_item.point_x;
      s1_pt[1] = head_item.point_y;
      s1_pt[2] = head_item.point_z;
      for (int r = 0; r < D; r++) begin
         for (int c = 0; c < 3; c++) begin
            s1_prod[r][c]    = view_ff[psp_pkg::MAT_IDX_W'(c * D + r)] * s1_pt[c];
            s1_term_in[r][c] = s1_prod[r][c][2*psp_pkg::Q_W-1:16];
         end
         s1_term_in[r][3] = psp_pkg::TERM_W'(view_ff[psp_pkg::MAT_IDX_W'(3 * D + r)]);
      end
   end

   // stage 2: eye vector
   always_comb begin
      for (int r = 0; r < D; r++) begin
         s2_sum[r] = s1_term_ff[r][0] + s1_term_ff[r][1] + s1_term_ff[r][2]
                   + s1_term_ff[r][3];
      end
   end

   // stage 3: projection products
   always_comb begin
      for (int r = 0; r < D; r++) begin
         for (int c = 0; c < D; c++) begin
            s3_prod[r][c] = proj_ff[psp_pkg::MAT_IDX_W'(c * D + r)] * s2_eye_ff[c];
         end
      end
   end

   // stage 4: clip vector
   always_comb begin
      for (int r = 0; r < D; r++) begin
         s4_sum[r] = s3_term_ff[r][0] + s3_term_ff[r][1] + s3_term_ff[r][2]
                   + s3_term_ff[r][3];
      end
   end

   // stage 5: (w + coord) for each axis
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s5_sum[a] = (psp_pkg::Q_W+1)'(s4_clip_ff[a]) + (psp_pkg::Q_W+1)'(s4_clip_ff[3]);
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_term_ff <= s1_term_in;
         s1_kind_ff <= head_item.kind;
         s1_idx_ff  <= head_item.coef_index;
         s1_val_ff  <= head_item.coef_value;
         s2_kind_ff <= s1_kind_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_val_ff  <= s1_val_ff;
         for (int r = 0; r < D; r++) begin
            s2_eye_ff[r]  <= psp_pkg::sat32(s2_sum[r]);
            s4_clip_ff[r] <= psp_pkg::sat32(s4_sum[r]);
            for (int c = 0; c < D; c++) begin
               s3_term_ff[r][c] <= s3_prod[r][c][2*psp_pkg::Q_W-1:16];
            end
         end
         s5_w_ff   <= s4_clip_ff[3];
         s5_deg_ff <= (s4_clip_ff[3] == '0);
         s6_den_ff <= {s5_w_ff, 1'b0};
         s6_deg_ff <= s5_deg_ff;
         s7_aden_ff <= s6_den_ff[psp_pkg::DEN_W-1] ? psp_pkg::DEN_W'(-s6_den_ff)
                                                   : psp_pkg::DEN_W'(s6_den_ff);
         s7_deg_ff <= s6_deg_ff;
         for (int a = 0; a < 2; a++) begin
            s5_prod_ff[a] <= psp_pkg::NUM_W'(s5_sum[a])
                           * psp_pkg::NUM_W'($signed({1'b0, size_ff[a]}));
            s6_num_ff[a]  <= s5_prod_ff[a] + psp_pkg::NUM_W'(s5_w_ff);
            s7_anum_ff[a] <= s6_num_ff[a][psp_pkg::NUM_W-1] ? psp_pkg::NUM_W'(-s6_num_ff[a])
                                                            : psp_pkg::NUM_W'(s6_num_ff[a]);
            s7_neg_ff[a]  <= s6_num_ff[a][psp_pkg::NUM_W-1] ^ s6_den_ff[psp_pkg::DEN_W-1];
         end
         dv_deg_ff[0] <= s7_deg_ff;
         for (int k = 1; k < psp_pkg::DIV_STAGES; k++) begin
            dv_deg_ff[k] <= dv_deg_ff[k-1];
         end
      end
   end

   // item valid track, writes drop out after the projection store
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         for (int k = 0; k < psp_pkg::DIV_STAGES; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff <= head_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff && (s2_kind_ff == psp_pkg::KIND_POINT);
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         dv_vld_ff[0] <= s7_vld_ff;
         for (int k = 1; k < psp_pkg::DIV_STAGES; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
      end
   end

   // per-axis dividers
   for (genvar a = 0; a < 2; a++) begin : g_axis
      psp_divide u_div (
         .clock  (clock),
         .adv    (adv),
         .in_num (s7_anum_ff[a]),
         .in_den (s7_aden_ff),
         .in_neg (s7_neg_ff[a]),
         .quo    (quo[a])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld_ff[psp_pkg::DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         degenerate_ff <= dv_deg_ff[psp_pkg::DIV_STAGES-1];
         screen_x_ff   <= dv_deg_ff[psp_pkg::DIV_STAGES-1] ? '0 : quo[0];
         screen_y_ff   <= dv_deg_ff[psp_pkg::DIV_STAGES-1] ? '0 : quo[1];
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.screen_x   = screen_x_ff;
   assign rsp_bus.screen_y   = screen_y_ff;
   assign rsp_bus.degenerate = degenerate_ff;

endmodule

// ===== rtl/core/point_screen_projection.sv =====
// ----------------------------------------------------------------------------
// point_screen_projection: world point to window pixel projection
// Queued front end feeding a pipelined view/projection/viewport back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries items: mode 0 and 1 load one view or projection matrix
//   entry (no response), mode 2 projects a point, mode 3 is dropped.
//   rsp_bus returns one response per projected point, in request order.
//   csr_* writes the viewport width (index 0) and height (index 1); write
//   them only while no item is in flight.
// Path: from request acceptance to response valid an item passes the
//   two matrix product stages, the mapping stages and the 17-stage divider
//   (one quotient bit per stage), then the output register.
// Throughput: one item per cycle unless stalled; writes and points may be
//   mixed freely, a matrix write affects only the points that follow it.
// Reset: queue and pipeline are emptied, viewport returns to 1920 x 1080;
//   matrix entries hold no value until loaded.
// Stall: rsp_bus.valid with ready low holds the whole back end; the two-entry
//   queue keeps taking requests until it fills, then req_bus.ready drops.
// ----------------------------------------------------------------------------
module point_screen_projection (
   input  logic                             clock,
   input  logic                             reset,
   psp_req_if.sink                          req_bus,
   psp_rsp_if.source                        rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [psp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [psp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic              head_valid;
   psp_pkg::item_type head_item;
   logic              pop;

   // intake and queue
   psp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // transform pipeline
   psp_xform u_xform (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

   // degenerate responses carry zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.degenerate |-> rsp_bus.screen_x == '0 && rsp_bus.screen_y == '0)
      else $error("degenerate response with nonzero coordinates");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   // a full queue always has a head item for the back end
   assert property (@(posedge clock) disable iff (reset) !req_bus.ready |-> head_valid)
      else $error("request stalled with empty queue");

   // a queued item leaves once the output is free
   assert property (@(posedge clock) disable iff (reset)
      head_valid && (!rsp_bus.valid || rsp_bus.ready) |-> pop)
      else $error("queue head not taken while pipeline advances");

endmodule

// ===== sim/point_screen_projection_tb.sv =====
// ----------------------------------------------------------------------------
// point_screen_projection_tb: self-checking bench for the point projector
// Loads view and projection matrices, projects directed and random points
// under random idling and back-pressure, and compares every response with a
// fixed-point projection computed inside the bench.
// ----------------------------------------------------------------------------
module point_screen_projection_tb;

   localparam int LATENCY    = 25;
   localparam int IDLE_LIMIT = 4000;
   localparam int N_RANDOM   = 1200;

   // mode value with no meaning, dropped by the block
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic               degen;
   } pixel_type;

   typedef struct {
      logic [1:0]         mode;
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      bit                 typed;
      pixel_type          want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [psp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [psp_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   psp_req_if req_bus ();
   psp_rsp_if rsp_bus ();

   point_screen_projection dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic signed [31:0] view_m [16];
   logic signed [31:0] proj_m [16];
   logic [13:0]        vp_width = psp_pkg::VIEWPORT_WIDTH_RST;
   logic [13:0]        vp_height = psp_pkg::VIEWPORT_HEIGHT_RST;

   pixel_type pixel_queue [$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  hold_long = 1'b0;
   bit  hold_started = 1'b0;

   // floor of a q32.32 product to q16.16
   function automatic longint mul_floor(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
   endfunction

   function automatic logic signed [31:0] sat_q16(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] map_pixel(input longint c, input longint w,
                                                    input logic [13:0] size);
      longint q;
      q = ((w + c) * longint'({18'd0, size}) + w) / (2 * w);
      if (q > 32767) return 16'sh7fff;
      if (q < -32768) return 16'sh8000;
      return q[15:0];
   endfunction

   function automatic pixel_type project_point(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
      logic signed [31:0] pt [4];
      logic signed [31:0] eye [4];
      logic signed [31:0] clip [4];
      longint acc;
      pixel_type r;
      pt[0] = px; pt[1] = py; pt[2] = pz; pt[3] = 32'sh00010000;
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) acc += mul_floor(view_m[c*4+i], pt[c]);
         eye[i] = sat_q16(acc);
      end
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) acc += mul_floor(proj_m[c*4+i], eye[c]);
         clip[i] = sat_q16(acc);
      end
      if (clip[3] == 0) begin
         r.sx = 0; r.sy = 0; r.degen = 1'b1;
      end else begin
         r.sx = map_pixel(clip[0], clip[3], vp_width);
         r.sy = map_pixel(clip[1], clip[3], vp_height);
         r.degen = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // one sender gap: mostly none, otherwise usually short and rarely long
   task automatic send_gap();
      int n;
      n = ($urandom_range(0, 3) != 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [1:0] mode, input logic [3:0] idx,
                            input logic signed [31:0] val, input logic signed [31:0] px,
                            input logic signed [31:0] py, input logic signed [31:0] pz,
                            input bit typed, input pixel_type want);
      pixel_type p;
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.coef_index <= idx;
      req_bus.coef_value <= val;
      req_bus.point_x <= px;
      req_bus.point_y <= py;
      req_bus.point_z <= pz;
      do @(posedge clock); while (!req_bus.ready);
      case (mode)
         psp_pkg::MODE_VIEW_WR: begin
            view_m[idx] = val;
         end
         psp_pkg::MODE_PROJ_WR: begin
            proj_m[idx] = val;
         end
         psp_pkg::MODE_POINT: begin
            p = project_point(px, py, pz);
            if (typed && p != want) report_mismatch("typed row", int'(p), int'(want));
            pixel_queue.push_back(p);
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         send_gap();
      end
   endtask

   task automatic drain_and_write(input logic [psp_pkg::CSR_INDEX_W-1:0] idx,
                                  input logic [13:0] v);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == psp_pkg::CSR_VIEWPORT_WIDTH) vp_width = v; else vp_height = v;
   endtask

   function automatic logic signed [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh00010000;
         2: return -32'sh00010000;
         3: return 32'(int'($urandom_range(0, 262143)) - 131072);
         default: return 32'(int'($urandom_range(0, 8388607)) - 4194304);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'sh7fffffff;
         default: return 32'(int'($urandom_range(0, 16777215)) - 8388608);
      endcase
   endfunction

   // compare responses
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.screen_x, rsp_bus.screen_y, rsp_bus.degenerate};
         if (pixel_queue.size() == 0) begin
            report_mismatch("unexpected item", int'(got), 0);
         end else begin
            want = pixel_queue[0];
            pixel_queue.delete(0);
            if (got.sx !== want.sx) report_mismatch("screen_x", got.sx, want.sx);
            if (got.sy !== want.sy) report_mismatch("screen_y", got.sy, want.sy);
            if (got.degen !== want.degen) report_mismatch("degenerate", got.degen, want.degen);
         end
      end
   end

   // receiver idling, with one long hold when asked
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_bus.ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_long = 1'b0;
         end
         rsp_bus.ready <= 1'b1;
         n = $urandom_range(1, 6);
         repeat (n) @(posedge clock);
         if ($urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            repeat (n) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_type rows [$];
      stim_row_type r;
      pixel_type none;
      logic [3:0] k;
      int sent;
      none = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = psp_pkg::MODE_VIEW_WR;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.point_z = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity view, projection all zero: clip w is zero
      for (int i = 0; i < 16; i++) begin
         k = 4'(i);
         send_item(psp_pkg::MODE_VIEW_WR, k, (i % 5 == 0) ? 32'sh00010000 : 32'sh0,
                   0, 0, 0, 1'b0, none);
         send_item(psp_pkg::MODE_PROJ_WR, k, 32'sh0, 0, 0, 0, 1'b0, none);
      end
      // directed rows: degenerate w, ignored mode, extremes
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 0, 0, 0, 1, '{16'sd0, 16'sd0, 1'b1}});
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 32'sh7fffffff, 32'sh80000000,
                       32'sh7fffffff, 1, '{16'sd0, 16'sd0, 1'b1}});
      rows.push_back('{MODE_IGNORED, 4'd15, 32'shffffffff, 32'shffffffff, 32'shffffffff,
                       32'shffffffff, 0, none});
      // projection identity, w comes from the homogeneous one
      rows.push_back('{psp_pkg::MODE_PROJ_WR, 4'd0, 32'sh00010000, 0, 0, 0, 0, none});
      rows.push_back('{psp_pkg::MODE_PROJ_WR, 4'd5, 32'sh00010000, 0, 0, 0, 0, none});
      rows.push_back('{psp_pkg::MODE_PROJ_WR, 4'd10, 32'sh00010000, 0, 0, 0, 0, none});
      rows.push_back('{psp_pkg::MODE_PROJ_WR, 4'd15, 32'sh00010000, 0, 0, 0, 0, none});
      // origin maps to the viewport center
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 0, 0, 0, 1,
                       '{16'sd960, 16'sd540, 1'b0}});
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 32'sh00010000, -32'sh00010000, 0,
                       1, '{16'sd1920, 16'sd0, 1'b0}});
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 32'sh7fffffff, 32'sh80000000,
                       32'sh7fffffff, 1, '{16'sh7fff, 16'sh8000, 1'b0}});
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 32'sh00123456, 32'shfff01234,
                       32'sh00050000, 0, none});
      rows.push_back('{psp_pkg::MODE_PROJ_WR, 4'd15, 32'sh80000000, 0, 0, 0, 0, none});
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 32'sh00008000, 32'sh00004000, 0,
                       0, none});
      rows.push_back('{psp_pkg::MODE_PROJ_WR, 4'd15, 32'sh7fffffff, 0, 0, 0, 0, none});
      rows.push_back('{psp_pkg::MODE_POINT, 4'd0, 0, 32'sh80000000, 32'sh7fffffff,
                       32'sh80000000, 0, none});
      foreach (rows[i]) begin
         r = rows[i];
         send_item(r.mode, r.idx, r.val, r.px, r.py, r.pz, r.typed, r.want);
      end

      // viewport extremes
      drain_and_write(psp_pkg::CSR_VIEWPORT_WIDTH, 14'd0);
      drain_and_write(psp_pkg::CSR_VIEWPORT_HEIGHT, 14'd16383);
      send_item(psp_pkg::MODE_POINT, 4'd0, 0, 0, 0, 0, 1'b1, '{16'sd0, 16'sd8192, 1'b0});
      send_item(psp_pkg::MODE_POINT, 4'd0, 0, 32'sh00030000, 32'shfffd0000, 0, 1'b0, none);

      // random phases, each with its own viewport
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: drain_and_write(psp_pkg::CSR_VIEWPORT_WIDTH, 14'd16383);
            1: drain_and_write(psp_pkg::CSR_VIEWPORT_HEIGHT, 14'd0);
            default: begin
               drain_and_write(psp_pkg::CSR_VIEWPORT_WIDTH, 14'($urandom_range(0, 16383)));
               drain_and_write(psp_pkg::CSR_VIEWPORT_HEIGHT, 14'($urandom_range(0, 16383)));
            end
         endcase
         // receiver holds off once while the sender keeps offering
         if (ph == 2 && !hold_started) begin
            hold_started = 1'b1;
            hold_long = 1'b1;
         end
         sent = 0;
         while (sent < N_RANDOM / 5) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  k = 4'($urandom);
                  send_item($urandom_range(0, 1) ? psp_pkg::MODE_PROJ_WR
                                                 : psp_pkg::MODE_VIEW_WR, k,
                            rand_coef(), $urandom, $urandom, $urandom, 1'b0, none);
               end
               2: send_item(MODE_IGNORED, 4'($urandom), $urandom, $urandom, $urandom,
                            $urandom, 1'b0, none);
               default: begin
                  send_item(psp_pkg::MODE_POINT, 4'($urandom), $urandom, rand_coord(),
                            rand_coord(), rand_coord(), 1'b0, none);
               end
            endcase
            sent++;
         end
      end

      // wait for the tail
      req_bus.valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
